FILE: design/sha1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

  // Field widths of the two channels.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned WnumW  = 3;
  localparam int unsigned CountW = 61;
  localparam int unsigned LenW   = 64;
  localparam int unsigned RoundW = 7;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumWin    = 16;
  localparam int unsigned LastRound = 79;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;

  // Initial chaining values.
  localparam word_t H0 = 32'h67452301;
  localparam word_t H1 = 32'hEFCDAB89;
  localparam word_t H2 = 32'h98BADCFE;
  localparam word_t H3 = 32'h10325476;
  localparam word_t H4 = 32'hC3D2E1F0;

  // Round constants for the four groups of twenty rounds.
  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam byte_t PadMark = 8'h80;

  // Position of the last digest word.
  localparam logic [WnumW-1:0] LastWnum = 3'd4;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WordW - n));
  endfunction

  // Round function, chosen by the round group.
  function automatic word_t round_f(input logic [RoundW-1:0] t, input word_t b,
                                    input word_t c, input word_t d);
    if (t < 7'd20) begin
      round_f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic word_t round_k(input logic [RoundW-1:0] t);
    if (t < 7'd20) begin
      round_k = K0;
    end else if (t < 7'd40) begin
      round_k = K1;
    end else if (t < 7'd60) begin
      round_k = K2;
    end else begin
      round_k = K3;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/sha1md_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Message channel: at most one byte per item.
interface sha1md_in_if
  import sha1md_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic              byte_present;
  logic              end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

// Digest channel: one 32-bit digest word per item.
interface sha1md_out_if
  import sha1md_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  digest_word;
  logic [WnumW-1:0]  word_number;
  logic              last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

`default_nettype wire

FILE: design/sha1_message_digest.sv
`timescale 1ns / 1ps
`default_nettype none

// SHA-1 digest of a byte stream. Each item carries at most one message byte and
// a flag that closes the message; a closing item without a byte is allowed, so
// the empty message is covered. A byte item is taken at once, except that
// the byte completing a 64-byte block starts the compression: one shared round
// datapath runs the 80 rounds one per cycle, then a fold step adds the result
// into the chaining words; the input is not ready until that is done. On
// the closing item the block feeds the padding itself, one pad byte per cycle
// (0x80, zeros, eight length bytes), compressing one or two more blocks, and
// then offers the five digest words, most significant first, one per item; the
// fifth carries last_word. The input is not ready from the closing item until
// the fifth word is taken. The bit length is taken modulo 2^64.
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  sha1md_in_if.sink    in_item,
  sha1md_out_if.source out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [RoundW-1:0]   round_r, round_nxt;
  logic [CountW-1:0]   count_r, count_nxt;
  logic                pad_r, pad_nxt;
  logic                mark_r, mark_nxt;
  logic                wrap_r, wrap_nxt;
  logic                lastblk_r, lastblk_nxt;
  logic                fpend_r, fpend_nxt;
  logic [WnumW-1:0]    oidx_r, oidx_nxt;
  logic                out_valid_r, out_valid_nxt;
  word_t               chain_r [NumChain];
  word_t               chain_nxt [NumChain];

  // Datapath state.
  logic [23:0]         acc_r, acc_nxt;
  word_t               win_r [NumWin];
  word_t               win_nxt [NumWin];
  word_t               work_r [NumChain];
  word_t               work_nxt [NumChain];
  logic [LenW-1:0]     len_r, len_nxt;

  logic [CountW-1:0]   count_inc;
  logic [5:0]          pos;
  logic                feed_en;
  byte_t               feed_byte;
  logic                in_fire;
  logic                out_fire;
  word_t               w_new;
  word_t               w_use;
  word_t               round_sum;

  assign count_inc = count_r + 61'd1;
  assign pos       = count_r[5:0];
  assign in_fire   = in_item.valid && in_item.ready;
  assign out_fire  = out_item.valid && out_item.ready;

  assign in_item.ready         = (state_r == S_IDLE);
  assign out_item.valid        = out_valid_r;
  assign out_item.digest_word  = chain_r[oidx_r];
  assign out_item.word_number  = oidx_r;
  assign out_item.last_word    = (oidx_r == LastWnum);

  // Schedule expansion and one compression round from fixed window taps.
  assign w_new     = rotl(win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0], 1);
  assign w_use     = (round_r < 7'd16) ? win_r[0] : w_new;
  assign round_sum = rotl(work_r[0], 5) + round_f(round_r, work_r[1], work_r[2], work_r[3])
                     + work_r[4] + w_use + round_k(round_r);

  // Byte source: message bytes when idle, padding bytes while padding.
  always_comb begin
    feed_en   = 1'b0;
    feed_byte = in_item.data_byte;
    if (state_r == S_IDLE) begin
      feed_en = in_fire && in_item.byte_present;
    end else if (state_r == S_PAD) begin
      feed_en = 1'b1;
      if (!mark_r) begin
        feed_byte = PadMark;
      end else if (wrap_r || pos < 6'd56) begin
        feed_byte = '0;
      end else begin
        feed_byte = len_r[LenW-1 -: ByteW];
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    count_nxt     = count_r;
    pad_nxt       = pad_r;
    mark_nxt      = mark_r;
    wrap_nxt      = wrap_r;
    lastblk_nxt   = lastblk_r;
    fpend_nxt     = fpend_r;
    oidx_nxt      = oidx_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    len_nxt       = len_r;
    for (int i = 0; i < NumChain; i++) begin
      chain_nxt[i] = chain_r[i];
      work_nxt[i]  = work_r[i];
    end
    for (int i = 0; i < NumWin; i++) begin
      win_nxt[i] = win_r[i];
    end

    // Pack a byte big-endian; a full word shifts into the window.
    if (feed_en) begin
      count_nxt = count_inc;
      if (pos[1:0] == 2'd3) begin
        for (int i = 0; i < NumWin - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[NumWin-1] = {acc_r, feed_byte};
      end else begin
        acc_nxt = {acc_r[15:0], feed_byte};
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.byte_present && pos == 6'd63) begin
            state_nxt = S_ROUND;
            fpend_nxt = in_item.end_of_message;
          end else if (in_item.end_of_message) begin
            state_nxt = S_PAD;
            pad_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            wrap_nxt  = 1'b0;
            len_nxt   = {(in_item.byte_present ? count_inc : count_r), 3'b000};
          end
        end
      end

      S_PAD: begin
        if (!mark_r) begin
          mark_nxt = 1'b1;
          wrap_nxt = (pos >= 6'd56);
        end else if (!wrap_r && pos >= 6'd56) begin
          len_nxt = len_r << ByteW;
          if (pos == 6'd63) begin
            lastblk_nxt = 1'b1;
          end
        end
        if (pos == 6'd63) begin
          wrap_nxt  = 1'b0;
          state_nxt = S_ROUND;
        end
      end

      S_ROUND: begin
        for (int i = 0; i < NumWin - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[NumWin-1] = w_use;
        work_nxt[4] = work_r[3];
        work_nxt[3] = work_r[2];
        work_nxt[2] = rotl(work_r[1], 30);
        work_nxt[1] = work_r[0];
        work_nxt[0] = round_sum;
        if (round_r == RoundW'(LastRound)) begin
          round_nxt = '0;
          state_nxt = S_FOLD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end

      S_FOLD: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        if (lastblk_r) begin
          state_nxt     = S_OUT;
          oidx_nxt      = '0;
          out_valid_nxt = 1'b1;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else if (fpend_r) begin
          state_nxt = S_PAD;
          fpend_nxt = 1'b0;
          pad_nxt   = 1'b1;
          mark_nxt  = 1'b0;
          wrap_nxt  = 1'b0;
          len_nxt   = {count_r, 3'b000};
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_fire) begin
          if (oidx_r == LastWnum) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b0;
            count_nxt     = '0;
            pad_nxt       = 1'b0;
            mark_nxt      = 1'b0;
            wrap_nxt      = 1'b0;
            lastblk_nxt   = 1'b0;
            chain_nxt[0]  = H0;
            chain_nxt[1]  = H1;
            chain_nxt[2]  = H2;
            chain_nxt[3]  = H3;
            chain_nxt[4]  = H4;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Entering the rounds loads the working words from the chain.
    if (state_r != S_ROUND && state_nxt == S_ROUND) begin
      for (int i = 0; i < NumChain; i++) begin
        work_nxt[i] = chain_r[i];
      end
      round_nxt = '0;
    end
  end

  // Control registers, state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      round_r     <= '0;
      count_r     <= '0;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      wrap_r      <= 1'b0;
      lastblk_r   <= 1'b0;
      fpend_r     <= 1'b0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= H0;
      chain_r[1]  <= H1;
      chain_r[2]  <= H2;
      chain_r[3]  <= H3;
      chain_r[4]  <= H4;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      count_r     <= count_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      wrap_r      <= wrap_nxt;
      lastblk_r   <= lastblk_nxt;
      fpend_r     <= fpend_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NumChain; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    len_r <= len_nxt;
    for (int i = 0; i < NumChain; i++) begin
      work_r[i] <= work_nxt[i];
    end
    for (int i = 0; i < NumWin; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  // The input is never open while a digest word is pending.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.ready |-> !out_item.valid)
    else $error("input ready while digest word pending");

  // The round counter stays within one block.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= RoundW'(LastRound))
    else $error("round counter out of range");

  // The last round is always followed by the chaining update.
  a_round_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && round_r == RoundW'(LastRound)) |=> state_r == S_FOLD)
    else $error("missing chaining update after last round");

  // Taking the fifth word returns the block to accepting bytes.
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_item.last_word) |=> (in_item.ready && count_r == '0))
    else $error("block not idle after final digest word");

  // Digest words are offered only after the length block is compressed.
  a_out_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FOLD && oidx_r == '0))
    else $error("digest output started out of order");

endmodule

`default_nettype wire

FILE: dv/tb_sha1_message_digest.sv
`timescale 1ns / 1ps

module tb_sha1_message_digest;
  import sha1md_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned LongHold    = 500;
  localparam int unsigned MinItems    = 200;
  localparam int unsigned MinMessages = 12;

  // One expected digest word as it leaves the block.
  typedef struct packed {
    word_t            digest;
    logic [WnumW-1:0] wnum;
    logic             last;
  } digest_word_t;

  // Receiver behavior between long holds.
  typedef enum logic [1:0] {RxFree, RxRandom, RxThrottle} rx_mode_t;

  // Tracks the running SHA-1 state of the message stream and holds the digest
  // words that the block still owes.
  class digest_tracker;
    word_t          chain[NumChain];
    word_t          win[NumWin];
    logic [CountW-1:0] nbytes;
    digest_word_t   pending_words[$];

    function new();
      for (int i = 0; i < NumWin; i++) win[i] = '0;
      restart();
    endfunction

    function void restart();
      chain[0] = H0;
      chain[1] = H1;
      chain[2] = H2;
      chain[3] = H3;
      chain[4] = H4;
      nbytes   = '0;
    endfunction

    function word_t rol(word_t v, int unsigned n);
      return (v << n) | (v >> (WordW - n));
    endfunction

    // Eighty rounds over the window, folded into the chaining words.
    function void run_rounds();
      word_t a, b, c, d, e, w, f, k, sum;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          w = win[t];
        end else begin
          w = rol(win[(t - 3) & 15] ^ win[(t - 8) & 15] ^ win[(t - 14) & 15] ^
                  win[t & 15], 1);
          win[t & 15] = w;
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        sum = rol(a, 5) + f + e + w + k;
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // Pack one byte big-endian into the window; a full block is compressed.
    function void absorb_byte(byte_t v);
      int unsigned pos, wi, sh;
      pos = nbytes[5:0];
      wi  = pos >> 2;
      sh  = (3 - (pos & 3)) * 8;
      if ((pos & 3) == 0) begin
        win[wi] = {v, 24'h000000};
      end else begin
        win[wi] |= word_t'(v) << sh;
      end
      nbytes = nbytes + 1'b1;
      if (pos == 63) run_rounds();
    endfunction

    // Pad with the marker byte, zeros and the bit length, then queue the digest.
    function void close_message();
      int unsigned pos, wi, inw;
      word_t keep;
      logic [LenW-1:0] bit_len;
      digest_word_t dw;
      pos     = nbytes[5:0];
      wi      = pos >> 2;
      inw     = pos & 3;
      keep    = (inw == 0) ? '0 : (32'hFFFF_FFFF << (WordW - 8 * inw));
      bit_len = {nbytes, 3'b000};
      win[wi] = (win[wi] & keep) | (word_t'(PadMark) << ((3 - inw) * 8));
      for (int i = wi + 1; i < NumWin; i++) win[i] = '0;
      if (pos >= 56) begin
        run_rounds();
        for (int i = 0; i < NumWin; i++) win[i] = '0;
      end
      win[14] = bit_len[63:32];
      win[15] = bit_len[31:0];
      run_rounds();
      for (int i = 0; i < NumChain; i++) begin
        dw.digest = chain[i];
        dw.wnum   = i[WnumW-1:0];
        dw.last   = (dw.wnum == LastWnum);
        pending_words = {pending_words, dw};
      end
      restart();
    endfunction

    // Note one accepted input item.
    function void take_item(byte_t v, logic present, logic eom);
      if (present) absorb_byte(v);
      if (eom) close_message();
    endfunction

    // Compare one accepted digest word with the oldest one owed.
    function bit check_word(word_t w, logic [WnumW-1:0] n, logic l, output string why);
      digest_word_t want;
      why = "";
      if (pending_words.size() == 0) begin
        why = $sformatf(" unexpected digest word %h, word_number %0d", w, n);
        return 1'b0;
      end
      want = pending_words.pop_front();
      if (w !== want.digest)
        why = {why, $sformatf(" digest_word %h, want %h;", w, want.digest)};
      if (n !== want.wnum)
        why = {why, $sformatf(" word_number %0d, want %0d;", n, want.wnum)};
      if (l !== want.last)
        why = {why, $sformatf(" last_word %b, want %b;", l, want.last)};
      return why == "";
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sha1md_in_if  in_if();
  sha1md_out_if out_if();

  sha1_message_digest dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  digest_tracker digests = new();

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned items_taken;
  int unsigned messages_closed;
  int unsigned burst_left;
  bit          random_phase;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle counter for the run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d digest words outstanding",
             cycle_count, digests.pending());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch:%s", $time, msg);
    error_count++;
  endtask

  // Check every digest word that the receiver accepts.
  always @(posedge clk) begin
    string why;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (!digests.check_word(out_if.digest_word, out_if.word_number, out_if.last_word,
                              why)) begin
        report(why);
      end
    end
  end

  // Receiver: one long hold once the random part starts, else a changing mix
  // of always ready, random stalls and a fixed throttle.
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned phase;
    bit          long_hold_done;
    mode           = RxFree;
    mode_left      = 0;
    hold_left      = 0;
    phase          = 0;
    long_hold_done = 1'b0;
    out_if.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (random_phase && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = LongHold;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        phase++;
        case (mode)
          RxFree:     out_if.ready = 1'b1;
          RxRandom:   out_if.ready = ($urandom_range(0, 99) < 60);
          default:    out_if.ready = (phase % 3 == 0);
        endcase
      end
    end
  end

  // Sender pacing: bursts of random length, separated by random gaps that are
  // sometimes zero, so stretches run without idling.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_item(byte_t v, logic present, logic eom);
    pace();
    @(negedge clk);
    in_if.valid          = 1'b1;
    in_if.data_byte      = v;
    in_if.byte_present   = present;
    in_if.end_of_message = eom;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    digests.take_item(v, present, eom);
    if (present || eom) items_taken++;
    if (eom) messages_closed++;
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // A whole message of random content, with ignored items mixed in. The
  // closing item carries the last byte or no byte at all.
  task automatic send_message(int unsigned len, bit close_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte || len == 0) send_item(pick_byte(), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned edges[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 7)];
    return $urandom_range(0, 10);
  endfunction

  initial begin
    error_count          = 0;
    cycle_count          = 0;
    items_taken          = 0;
    messages_closed      = 0;
    burst_left           = 0;
    random_phase         = 1'b0;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.byte_present   = 1'b0;
    in_if.end_of_message = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty messages, ignored items, one-byte messages closed on the
    // byte, a message closed by an empty item, and "abc".
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);

    // Random messages, mostly short, some around the padding boundaries.
    random_phase = 1'b1;
    while (items_taken < MinItems || messages_closed < MinMessages) begin
      send_message(pick_length(), 1'($urandom_range(0, 1)));
    end
    @(negedge clk);
    in_if.valid = 1'b0;

    // Drain, then give any stray words time to show up.
    while (digests.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
